[hw/rtl/tlps_pkg.sv]
// Shared types and constants for the three-lane LED pulse serialiser.
`timescale 1ns / 1ps

package tlps_pkg;

    // Fixed geometry of the item fields and register port
    localparam int LANE_COUNT = 3;
    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Item action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd2;

    // Register reset values
    localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 8'd18;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 8'd4;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 8'd12;

    typedef struct packed {
        logic [TICK_W-1:0] bit_period;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_high;
    } cfg_t;

    typedef struct packed {
        logic                                action;
        logic [LANE_COUNT-1:0][BYTE_W-1:0]   lane_byte;
    } item_t;

    typedef struct packed {
        logic [LANE_COUNT-1:0] pins;
        logic                  busy;
        logic                  byte_done;
        logic                  load_dropped;
    } result_t;

endpackage

[hw/rtl/tlps_if.sv]
// Item channel interfaces: command items in, line level results out.
`timescale 1ns / 1ps

interface tlps_cmd_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [tlps_pkg::BYTE_W-1:0] lane_a_byte;
    logic [tlps_pkg::BYTE_W-1:0] lane_b_byte;
    logic [tlps_pkg::BYTE_W-1:0] lane_c_byte;

    modport source (
        output valid, action, lane_a_byte, lane_b_byte, lane_c_byte,
        input  ready
    );
    modport sink (
        input  valid, action, lane_a_byte, lane_b_byte, lane_c_byte,
        output ready
    );
endinterface

interface tlps_result_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic pin_c;
    logic busy_res;
    logic byte_done;
    logic load_dropped;

    modport source (
        output valid, pin_a, pin_b, pin_c, busy_res, byte_done, load_dropped,
        input  ready
    );
    modport sink (
        input  valid, pin_a, pin_b, pin_c, busy_res, byte_done, load_dropped,
        output ready
    );
endinterface

[hw/rtl/tlps_engine.sv]
// Serialiser state (shift registers, slot and bit counters) and per-item logic.
`timescale 1ns / 1ps

module tlps_engine #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tlps_pkg::item_t   item,
    input  tlps_pkg::cfg_t    cfg,
    output tlps_pkg::result_t result
);
    import tlps_pkg::*;

    localparam int CNT_W = $clog2(BITS_PER_BYTE + 1);

    logic [LANE_COUNT-1:0][BYTE_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]                  bits_reg, bits_next;
    logic [TICK_W-1:0]                 tick_reg, tick_next;
    logic                              busy;
    logic                              slot_end;
    logic [TICK_W-1:0]                 high_time;

    assign busy     = (bits_reg != '0);
    // Slot ends when the next tick index would reach the period
    assign slot_end = ({1'b0, tick_reg} + {{TICK_W{1'b0}}, 1'b1}) >= {1'b0, cfg.bit_period};

    // Next state and result for the item in hand
    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        tick_next  = tick_reg;
        result     = '0;
        high_time  = '0;
        if (item.action == ACT_LOAD)
        begin
            if (busy)
            begin
                result.load_dropped = 1'b1;
            end
            else
            begin
                shift_next = item.lane_byte;
                bits_next  = CNT_W'(BITS_PER_BYTE);
                tick_next  = '0;
            end
        end
        else if (busy)
        begin
            for (int l = 0; l < LANE_COUNT; l++)
            begin
                high_time      = shift_reg[l][BYTE_W-1] ? cfg.one_high : cfg.zero_high;
                result.pins[l] = (tick_reg < high_time);
            end
            if (slot_end)
            begin
                tick_next = '0;
                for (int l = 0; l < LANE_COUNT; l++)
                begin
                    shift_next[l] = {shift_reg[l][BYTE_W-2:0], 1'b0};
                end
                bits_next        = bits_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                result.byte_done = (bits_next == '0);
            end
            else
            begin
                tick_next = tick_reg + {{(TICK_W-1){1'b0}}, 1'b1};
            end
        end
        result.busy = (bits_next != '0);
    end

    // State advances only when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            tick_reg  <= '0;
        end
        else if (advance)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

[hw/rtl/three_lane_led_pulse_serializer_top.sv]
// Top level: APB registers, input register, serialiser engine, result register.
// Path: an accepted item is held in the input register, passes through the
//   engine, and loads into the result register when that is free or draining.
// Throughput: one item per cycle, loads and ticks alike, unless result.ready
//   is low; set by the single engine pass between input and result registers.
// Reset (rst_n low, asynchronous): both stages empty, shift registers and
//   counters cleared, registers back to period 18, zero high 4, one high 12.
`timescale 1ns / 1ps

module three_lane_led_pulse_serializer_top #(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tlps_cmd_if.sink                            cmd,
    tlps_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tlps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tlps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tlps_pkg::*;

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    logic        item_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     eng_result;
    logic        advance;
    item_t       cmd_item;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period <= BIT_PERIOD_RST;
            cfg_reg.zero_high  <= ZERO_HIGH_RST;
            cfg_reg.one_high   <= ONE_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_BIT_PERIOD: cfg_reg.bit_period <= pwdata[TICK_W-1:0];
                REG_ZERO_HIGH:  cfg_reg.zero_high  <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   cfg_reg.one_high   <= pwdata[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BIT_PERIOD: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, cfg_reg.bit_period};
            REG_ZERO_HIGH:  prdata = {{(APB_DATA_W-TICK_W){1'b0}}, cfg_reg.zero_high};
            REG_ONE_HIGH:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, cfg_reg.one_high};
            default:        prdata = '0;
        endcase
    end

    // Handshake: item moves on when the result register is free or draining
    assign advance   = item_valid_reg && (!out_valid_reg || result.ready);
    assign cmd.ready = !item_valid_reg || advance;

    assign cmd_item.action       = cmd.action;
    assign cmd_item.lane_byte[0] = cmd.lane_a_byte;
    assign cmd_item.lane_byte[1] = cmd.lane_b_byte;
    assign cmd_item.lane_byte[2] = cmd.lane_c_byte;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            item_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd_item;
        end
    end

    tlps_engine #(
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (eng_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= eng_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.pin_a        = out_reg.pins[0];
    assign result.pin_b        = out_reg.pins[1];
    assign result.pin_c        = out_reg.pins[2];
    assign result.busy_res     = out_reg.busy;
    assign result.byte_done    = out_reg.byte_done;
    assign result.load_dropped = out_reg.load_dropped;

endmodule

[hw/rtl/tlps_checker.sv]
// Port-level checks on the serialiser top level, bound into every instance.
`timescale 1ns / 1ps

module tlps_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic pin_a,
    input logic pin_b,
    input logic pin_c,
    input logic busy_res,
    input logic byte_done,
    input logic load_dropped,
    input logic pready
);

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({pin_a, pin_b, pin_c, busy_res, byte_done, load_dropped}))
        else $error("result changed while stalled");

    // The last bit slot leaves nothing to send
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_done |-> !busy_res)
        else $error("byte_done with bits still pending");

    // A dropped load only happens while busy and drives no waveform
    a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_dropped |-> busy_res && !byte_done && !pin_a && !pin_b && !pin_c)
        else $error("dropped load result inconsistent");

    // Register port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind three_lane_led_pulse_serializer_top tlps_checker u_tlps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .pin_a        (result.pin_a),
    .pin_b        (result.pin_b),
    .pin_c        (result.pin_c),
    .busy_res     (result.busy_res),
    .byte_done    (result.byte_done),
    .load_dropped (result.load_dropped),
    .pready       (pready)
);
